>>> rtl/core/rpwd_pkg.sv
// ============================================================================
// rpwd_pkg: shared types, constants and helpers of the ring producer block
// Ring geometry, record sizes, codes, word formats and fill arithmetic.
// ============================================================================
package rpwd_pkg;

  // Ring geometry and record sizes.
  localparam int RingOrder     = 20;
  localparam int HeaderBytes   = 16;
  localparam int DropBodyBytes = 24;
  localparam int DropBytes     = HeaderBytes + DropBodyBytes;
  localparam int PctScale      = 100;

  // Field widths.
  localparam int CmdW    = 2;
  localparam int LenW    = 16;
  localparam int CntW    = 64;
  localparam int StatW   = 2;
  localparam int KindW   = 2;
  localparam int OffsetW = 20;
  localparam int RecW    = 17;
  localparam int LostW   = 32;
  localparam int PctW    = 7;
  localparam int CfgIdxW = 1;

  // Free room and clamped fill never exceed the ring size itself.
  localparam int FreeW = RingOrder + 1;
  localparam int ProdW = FreeW + PctW;

  localparam logic [CntW-1:0]  RingSize  = CntW'(1) << RingOrder;
  localparam logic [CntW-1:0]  RingMask  = RingSize - CntW'(1);
  localparam logic [RecW-1:0]  DropRec   = RecW'(DropBytes);
  localparam logic [RecW-1:0]  HeaderRec = RecW'(HeaderBytes);
  localparam logic [ProdW-1:0] PctMul    = ProdW'(PctScale);

  typedef enum logic [CmdW-1:0] {
    CmdPush    = 2'd0,
    CmdAdvance = 2'd1,
    CmdReset   = 2'd2,
    CmdStatus  = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StatOk      = 2'd0,
    StatDropped = 2'd1,
    StatBadTail = 2'd2
  } status_e;

  typedef enum logic [KindW-1:0] {
    KindNone   = 2'd0,
    KindPacket = 2'd1,
    KindDrop   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHighPercent = 1'b0,
    CfgLowPercent  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [LenW-1:0] payload_length;
    logic [CntW-1:0] tail_req;
    logic [CntW-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [KindW-1:0]   record_kind;
    logic [OffsetW-1:0] write_offset;
    logic [RecW-1:0]    record_bytes;
    logic [LostW-1:0]   lost_packets;
    logic [CntW-1:0]    drop_start_time;
    logic [CntW-1:0]    head_count;
    logic [CntW-1:0]    tail_count;
    logic               event_raised;
    logic               readable;
    logic [CntW-1:0]    stat_value;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0]  head_total;
    logic [CntW-1:0]  tail_total;
    logic             dropping;
    logic [LostW-1:0] lost_in_episode;
    logic [CntW-1:0]  episode_start;
    logic             above_high;
    logic [CntW-1:0]  drop_total;
    logic [CntW-1:0]  record_total;
    logic [CntW-1:0]  byte_total;
  } ring_state_t;

  // Everything one item produces: the next state, up to three words and
  // the position of the final word.
  typedef struct packed {
    ring_state_t         state;
    result_t [2:0]       words;
    logic [1:0]          last_idx;
  } step_t;

  // Fill percentage; a fill beyond the ring size counts as a full ring.
  function automatic logic [PctW-1:0] fill_pct(logic [CntW-1:0] head,
                                               logic [CntW-1:0] tail);
    logic [CntW-1:0]  used;
    logic [FreeW-1:0] clamp;
    logic [ProdW-1:0] prod;
    used  = head - tail;
    clamp = (used > RingSize) ? RingSize[FreeW-1:0] : used[FreeW-1:0];
    prod  = ProdW'(clamp) * PctMul;
    return PctW'(prod >> RingOrder);
  endfunction

  // Free room in bytes, zero when the counts are out of range.
  function automatic logic [FreeW-1:0] fill_free(logic [CntW-1:0] head,
                                                 logic [CntW-1:0] tail);
    logic [CntW-1:0] used;
    logic [CntW-1:0] room;
    used = head - tail;
    room = RingSize - used;
    return (used > RingSize) ? '0 : room[FreeW-1:0];
  endfunction

  // Byte offset inside the ring where a record starting at head lands.
  function automatic logic [OffsetW-1:0] ring_offset(logic [CntW-1:0] head);
    return head[OffsetW-1:0] & RingMask[OffsetW-1:0];
  endfunction

endpackage

>>> rtl/core/ring_producer_watermark_drop.sv
// ============================================================================
// ring_producer_watermark_drop: producer bookkeeping for a byte ring
// Head and tail counts, drop episodes, watermark events and statistics.
// ============================================================================
// A command waits in the command register while queued words remain, then its
// first result word is registered and the rest follow back to back. One
// command per cycle while busy is low; busy stalls a command while the extra
// words of a push that closes a drop episode or of a status read are shown,
// one per cycle. Reset clears all counts and flags and sets watermarks to 50
// and 30 percent; the receiver cannot stall, so each word shows for one cycle.
module ring_producer_watermark_drop (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Command channel.
  input  logic                             start,
  output logic                             busy,
  input  rpwd_pkg::item_t                  item_i,
  // Result channel.
  output logic                             result_strobe_o,
  output rpwd_pkg::result_t                result_o,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rpwd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rpwd_pkg::PctW-1:0]        cfg_data_i
);

  // Command register: a word waits here while queued results drain.
  rpwd_pkg::item_t       item_q, item_d;
  logic                  item_valid_q, item_valid_d;

  // Ring state and watermark registers.
  rpwd_pkg::ring_state_t state_q, state_d;
  logic [rpwd_pkg::PctW-1:0] high_q, high_d;
  logic [rpwd_pkg::PctW-1:0] low_q, low_d;

  rpwd_pkg::step_t       step;
  logic                  stall;
  logic                  accept;
  logic                  take;

  // The command register is only blocked while the output side still has
  // words of an earlier command to show.
  assign busy   = item_valid_q && stall;
  assign accept = start && !busy;
  assign take   = item_valid_q && !stall;

  always_comb begin
    item_d       = accept ? item_i : item_q;
    item_valid_d = accept || (item_valid_q && !take);
  end

  // State only moves when a command is evaluated.
  assign state_d = take ? step.state : state_q;

  // Configuration is only taken while no command waits for evaluation, so the
  // watermarks cannot change while a command waits in the command register.
  assign cfg_ready_o = !item_valid_q;

  always_comb begin
    high_d = high_q;
    low_d  = low_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rpwd_pkg::CfgHighPercent: high_d = cfg_data_i;
        rpwd_pkg::CfgLowPercent:  low_d  = cfg_data_i;
        default:                  high_d = high_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      state_q      <= '0;
      high_q       <= rpwd_pkg::PctW'(50);
      low_q        <= rpwd_pkg::PctW'(30);
    end else begin
      item_valid_q <= item_valid_d;
      state_q      <= state_d;
      high_q       <= high_d;
      low_q        <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  // Single pass from the command register to the result register.
  rpwd_step u_step (
    .item_i     (item_q),
    .state_i    (state_q),
    .high_pct_i (high_q),
    .low_pct_i  (low_q),
    .step_o     (step)
  );

  rpwd_out_seq u_out_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take),
    .step_i   (step),
    .result_o (result_o),
    .strobe_o (result_strobe_o),
    .stall_o  (stall)
  );

endmodule

>>> rtl/core/rpwd_step.sv
// ============================================================================
// rpwd_step: one-pass evaluation of a command
// Works out the next ring state and every result word of one command.
// ============================================================================
module rpwd_step (
  input  rpwd_pkg::item_t                   item_i,
  input  rpwd_pkg::ring_state_t             state_i,
  input  logic [rpwd_pkg::PctW-1:0]         high_pct_i,
  input  logic [rpwd_pkg::PctW-1:0]         low_pct_i,
  output rpwd_pkg::step_t                   step_o
);

  logic [rpwd_pkg::RecW-1:0]  need;
  logic [rpwd_pkg::RecW-1:0]  total;
  logic [rpwd_pkg::FreeW-1:0] room;
  logic                       fits;
  logic                       bad_tail;
  logic                       wm_eval;
  logic                       evt;
  logic [rpwd_pkg::PctW-1:0]  pct_nxt;
  rpwd_pkg::ring_state_t      st;
  rpwd_pkg::result_t [2:0]    words;
  logic [1:0]                 last_idx;

  assign need  = rpwd_pkg::HeaderRec + rpwd_pkg::RecW'(item_i.payload_length);
  assign total = state_i.dropping ? need + rpwd_pkg::DropRec : need;
  assign room  = rpwd_pkg::fill_free(state_i.head_total, state_i.tail_total);
  assign fits  = rpwd_pkg::CntW'(room) >= rpwd_pkg::CntW'(total);
  assign bad_tail = (item_i.tail_req > state_i.head_total) ||
                    (item_i.tail_req < state_i.tail_total);

  always_comb begin
    st       = state_i;
    words    = '0;
    last_idx = 2'd0;
    wm_eval  = 1'b0;
    evt      = 1'b0;

    case (item_i.command)
      rpwd_pkg::CmdPush: begin
        if (!fits) begin
          // Open an episode on the first loss, then count the loss.
          st.dropping        = 1'b1;
          st.episode_start   = state_i.dropping ? state_i.episode_start
                                                : item_i.now_time;
          st.lost_in_episode = (state_i.dropping ? state_i.lost_in_episode : '0)
                               + rpwd_pkg::LostW'(1);
          st.drop_total      = state_i.drop_total + rpwd_pkg::CntW'(1);
          words[0].status    = rpwd_pkg::StatDropped;
        end else begin
          if (state_i.dropping) begin
            // The drop record sits at the head, the packet right behind it.
            words[0].record_kind     = rpwd_pkg::KindDrop;
            words[0].write_offset    = rpwd_pkg::ring_offset(state_i.head_total);
            words[0].record_bytes    = rpwd_pkg::DropRec;
            words[0].lost_packets    = state_i.lost_in_episode;
            words[0].drop_start_time = state_i.episode_start;
            words[1].record_kind     = rpwd_pkg::KindPacket;
            words[1].write_offset    = rpwd_pkg::ring_offset(
              state_i.head_total + rpwd_pkg::CntW'(rpwd_pkg::DropRec));
            words[1].record_bytes    = need;
            last_idx                 = 2'd1;
            st.record_total          = state_i.record_total + rpwd_pkg::CntW'(2);
          end else begin
            words[0].record_kind  = rpwd_pkg::KindPacket;
            words[0].write_offset = rpwd_pkg::ring_offset(state_i.head_total);
            words[0].record_bytes = need;
            st.record_total       = state_i.record_total + rpwd_pkg::CntW'(1);
          end
          st.head_total = state_i.head_total + rpwd_pkg::CntW'(total);
          st.byte_total = state_i.byte_total + rpwd_pkg::CntW'(total);
          st.dropping   = 1'b0;
          wm_eval       = 1'b1;
        end
      end
      rpwd_pkg::CmdAdvance: begin
        if (bad_tail) begin
          words[0].status = rpwd_pkg::StatBadTail;
        end else begin
          st.tail_total = item_i.tail_req;
          wm_eval       = 1'b1;
        end
      end
      rpwd_pkg::CmdReset: begin
        st = '0;
      end
      rpwd_pkg::CmdStatus: begin
        words[0].stat_value = state_i.drop_total;
        words[1].stat_value = state_i.record_total;
        words[2].stat_value = state_i.byte_total;
        last_idx            = 2'd2;
      end
      default: begin
        st = state_i;
      end
    endcase

    // Watermarks with hysteresis, on the fill after this command.
    pct_nxt = rpwd_pkg::fill_pct(st.head_total, st.tail_total);
    if (wm_eval) begin
      if (!state_i.above_high && (pct_nxt >= high_pct_i)) begin
        st.above_high = 1'b1;
        evt           = 1'b1;
      end else if (state_i.above_high && (pct_nxt <= low_pct_i)) begin
        st.above_high = 1'b0;
      end
    end

    for (int k = 0; k < 3; k++) begin
      words[k].head_count   = st.head_total;
      words[k].tail_count   = st.tail_total;
      words[k].readable     = pct_nxt >= high_pct_i;
      words[k].last         = 2'(k) == last_idx;
      words[k].event_raised = evt && (2'(k) == last_idx);
    end

    step_o.state    = st;
    step_o.words    = words;
    step_o.last_idx = last_idx;
  end

endmodule

>>> rtl/core/rpwd_out_seq.sv
// ============================================================================
// rpwd_out_seq: result register and follow-on word queue
// Shows one word per cycle and holds the extra words of one command.
// ============================================================================
module rpwd_out_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rpwd_pkg::step_t   step_i,
  output rpwd_pkg::result_t result_o,
  output logic              strobe_o,
  output logic              stall_o
);

  rpwd_pkg::result_t out_q, out_d;
  rpwd_pkg::result_t pend_q [2];
  rpwd_pkg::result_t pend_d [2];
  logic              strobe_q, strobe_d;
  logic [1:0]        cnt_q, cnt_d;

  always_comb begin
    out_d     = out_q;
    pend_d[0] = pend_q[0];
    pend_d[1] = pend_q[1];
    cnt_d     = cnt_q;
    strobe_d  = 1'b0;
    if (cnt_q != 2'd0) begin
      // Drain the queued words of the previous command first.
      out_d     = pend_q[0];
      pend_d[0] = pend_q[1];
      cnt_d     = cnt_q - 2'd1;
      strobe_d  = 1'b1;
    end else if (load_i) begin
      out_d     = step_i.words[0];
      pend_d[0] = step_i.words[1];
      pend_d[1] = step_i.words[2];
      cnt_d     = step_i.last_idx;
      strobe_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      strobe_q <= strobe_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    pend_q[0] <= pend_d[0];
    pend_q[1] <= pend_d[1];
  end

  assign result_o = out_q;
  assign strobe_o = strobe_q;
  assign stall_o  = cnt_q != 2'd0;

endmodule

>>> rtl/core/rpwd_checker.sv
// ============================================================================
// rpwd_checker: port-level checks of the ring producer block
// Word sequencing rules seen on the result and command ports.
// ============================================================================
module rpwd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy_i,
  input logic              strobe_i,
  input rpwd_pkg::result_t result_i
);

  // Busy only covers cycles in which queued words are being shown.
  a_busy_shows_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> strobe_i)
    else $error("busy without a result word");

  // A word that is not the final one is followed at once by another.
  a_words_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_i && !result_i.last) |=> strobe_i)
    else $error("gap inside a multi-word result");

  // A drop record is always followed by its packet record.
  a_drop_then_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_i && (result_i.record_kind == rpwd_pkg::KindDrop)) |=>
      (strobe_i && (result_i.record_kind == rpwd_pkg::KindPacket)))
    else $error("drop record not followed by packet record");

  // Events are reported on the final word only.
  a_event_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_i && result_i.event_raised) |-> result_i.last)
    else $error("event on a non-final word");

  // A failed command writes no record and ends with that single word.
  a_fail_no_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_i && (result_i.status != rpwd_pkg::StatOk)) |->
      (result_i.last && (result_i.record_kind == rpwd_pkg::KindNone)))
    else $error("failed command carries a record");

endmodule

bind ring_producer_watermark_drop rpwd_checker u_rpwd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .busy_i   (busy),
  .strobe_i (result_strobe_o),
  .result_i (result_o)
);

>>> sim/ring_producer_watermark_drop_checker.sv
// ============================================================================
// ring_producer_watermark_drop_checker: word predictor and comparator
// Follows every accepted command and register write, works out the result
// words the ring bookkeeping must show and compares them on arrival.
// ============================================================================
module ring_producer_watermark_drop_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  rpwd_pkg::item_t              item_i,
  input  logic                         strobe_i,
  input  rpwd_pkg::result_t            result_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [rpwd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rpwd_pkg::PctW-1:0]    cfg_data_i,
  output int                           errors_o,
  output int                           pending_o,
  output logic [rpwd_pkg::CntW-1:0]    ring_head_o,
  output logic [rpwd_pkg::CntW-1:0]    ring_tail_o
);
  import rpwd_pkg::*;

  // Shadow of the ring bookkeeping.
  logic [PctW-1:0]  mark_high;
  logic [PctW-1:0]  mark_low;
  logic [CntW-1:0]  head_cnt;
  logic [CntW-1:0]  tail_cnt;
  logic             in_episode;
  logic [LostW-1:0] episode_lost;
  logic [CntW-1:0]  episode_t0;
  logic             high_state;
  logic [CntW-1:0]  drops_seen;
  logic [CntW-1:0]  records_made;
  logic [CntW-1:0]  bytes_placed;

  result_t due_words[$];

  assign ring_head_o = head_cnt;
  assign ring_tail_o = tail_cnt;

  function automatic logic [CntW-1:0] room_left();
    logic [CntW-1:0] used;
    used = head_cnt - tail_cnt;
    return (used > RingSize) ? '0 : RingSize - used;
  endfunction

  function automatic logic [CntW-1:0] fill_percent();
    logic [CntW-1:0] used;
    used = head_cnt - tail_cnt;
    if (used > RingSize) used = RingSize;
    return (used * CntW'(PctScale)) >> RingOrder;
  endfunction

  // Hysteresis: enter at or above the high mark, leave at or below the low.
  function automatic logic crossing_up();
    logic [CntW-1:0] pct;
    pct = fill_percent();
    if (!high_state && pct >= CntW'(mark_high)) begin
      high_state = 1'b1;
      return 1'b1;
    end
    if (high_state && pct <= CntW'(mark_low)) high_state = 1'b0;
    return 1'b0;
  endfunction

  task automatic place_record(inout result_t w, input kind_e kind,
                              input logic [CntW-1:0] nbytes);
    w.record_kind  = kind;
    w.write_offset = OffsetW'(head_cnt & RingMask);
    w.record_bytes = RecW'(nbytes);
    records_made   = records_made + 1;
    bytes_placed   = bytes_placed + nbytes;
    head_cnt       = head_cnt + nbytes;
  endtask

  task automatic book_item(input item_t it);
    result_t         w[3];
    int              n;
    logic            ev;
    logic [CntW-1:0] need;
    logic [CntW-1:0] total;
    n  = 1;
    ev = 1'b0;
    for (int k = 0; k < 3; k++) w[k] = '0;
    case (cmd_e'(it.command))
      CmdPush: begin
        need  = CntW'(HeaderBytes) + CntW'(it.payload_length);
        total = in_episode ? need + CntW'(DropBytes) : need;
        if (room_left() < total) begin
          if (!in_episode) begin
            in_episode   = 1'b1;
            episode_t0   = it.now_time;
            episode_lost = '0;
          end
          episode_lost = episode_lost + 1;
          drops_seen   = drops_seen + 1;
          w[0].status  = StatDropped;
        end else begin
          // Closing an episode: the drop record sits at the head and the
          // packet follows straight after it.
          if (in_episode) begin
            place_record(w[0], KindDrop, CntW'(DropBytes));
            w[0].lost_packets    = episode_lost;
            w[0].drop_start_time = episode_t0;
            in_episode = 1'b0;
            n = 2;
          end
          place_record(w[n-1], KindPacket, need);
          ev = crossing_up();
        end
      end
      CmdAdvance: begin
        if (it.tail_req > head_cnt || it.tail_req < tail_cnt) begin
          w[0].status = StatBadTail;
        end else begin
          tail_cnt = it.tail_req;
          ev = crossing_up();
        end
      end
      CmdReset: begin
        head_cnt     = '0;
        tail_cnt     = '0;
        in_episode   = 1'b0;
        episode_lost = '0;
        episode_t0   = '0;
        high_state   = 1'b0;
        drops_seen   = '0;
        records_made = '0;
        bytes_placed = '0;
      end
      default: begin
        n = 3;
        w[0].stat_value = drops_seen;
        w[1].stat_value = records_made;
        w[2].stat_value = bytes_placed;
      end
    endcase
    for (int k = 0; k < n; k++) begin
      w[k].head_count = head_cnt;
      w[k].tail_count = tail_cnt;
      w[k].readable   = (fill_percent() >= CntW'(mark_high));
    end
    w[n-1].event_raised = ev;
    w[n-1].last         = 1'b1;
    for (int k = 0; k < n; k++) due_words.push_back(w[k]);
  endtask

  function automatic void show_word(string tag, result_t w);
    $display("  %s st=%0d kind=%0d off=%h bytes=%h lost=%h t0=%h", tag, w.status,
             w.record_kind, w.write_offset, w.record_bytes, w.lost_packets,
             w.drop_start_time);
    $display("  %s head=%h tail=%h ev=%b rd=%b stat=%h last=%b", tag, w.head_count,
             w.tail_count, w.event_raised, w.readable, w.stat_value, w.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      mark_high    = PctW'(50);
      mark_low     = PctW'(30);
      head_cnt     = '0;
      tail_cnt     = '0;
      in_episode   = 1'b0;
      episode_lost = '0;
      episode_t0   = '0;
      high_state   = 1'b0;
      drops_seen   = '0;
      records_made = '0;
      bytes_placed = '0;
      due_words.delete();
      errors_o     = 0;
      pending_o    = 0;
    end else begin
      if (strobe_i) begin
        if (due_words.size() == 0) begin
          errors_o = errors_o + 1;
          if (errors_o <= 10) begin
            $display("word with nothing due at %0t", $time);
            show_word("got", result_i);
          end
        end else begin
          want = due_words.pop_front();
          if (result_i !== want) begin
            errors_o = errors_o + 1;
            if (errors_o <= 10) begin
              $display("word mismatch at %0t", $time);
              show_word("exp", want);
              show_word("got", result_i);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgHighPercent: mark_high = cfg_data_i;
          default:        mark_low  = cfg_data_i;
        endcase
      end
      if (start_i && !busy_i) book_item(item_i);
      pending_o = due_words.size();
    end
  end

endmodule

>>> sim/tb_ring_producer_watermark_drop.sv
// ============================================================================
// tb_ring_producer_watermark_drop: testbench of the ring producer block
// Drives directed and random commands and register writes, with random
// gaps, into the block; a checker beside it predicts and compares words.
// ============================================================================
module tb_ring_producer_watermark_drop;
  import rpwd_pkg::*;

  // Ways of choosing tail_req for an advance, settled at the moment the
  // command is driven so that the current head and tail are known.
  localparam int TailKeep   = 0;
  localparam int TailAtHead = 1;
  localparam int TailInside = 2;
  localparam int TailAtTail = 3;
  localparam int TailAbove  = 4;
  localparam int TailUnder  = 5;

  // Silent cycles before the run is declared hung.
  localparam int WatchdogLimit = 2000;
  localparam int Phases        = 8;
  localparam int PhaseItems    = 45;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  item_t             item_i;
  logic              result_strobe_o;
  result_t           result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [PctW-1:0]   cfg_data_i;

  int                errors;
  int                pending;
  logic [CntW-1:0]   ring_head;
  logic [CntW-1:0]   ring_tail;
  int                calm_left;
  int                quiet_cycles;

  ring_producer_watermark_drop dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  ring_producer_watermark_drop_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item_i),
    .strobe_i    (result_strobe_o),
    .result_i    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .ring_head_o (ring_head),
    .ring_tail_o (ring_tail)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The watchdog restarts on every accepted command, register write or
  // result word; a long silence means the block has hung.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout after %0d silent cycles", quiet_cycles);
      $display("tb_ring_producer_watermark_drop NOT OK");
      $finish;
    end
  end

  function automatic item_t mk(logic [CmdW-1:0] cmd, logic [LenW-1:0] len,
                               logic [CntW-1:0] tail, logic [CntW-1:0] stamp);
    item_t it;
    it.command        = cmd;
    it.payload_length = len;
    it.tail_req       = tail;
    it.now_time       = stamp;
    return it;
  endfunction

  // Sends one command word. The gap before it is drawn per word, with the
  // odd stretch of back-to-back words. While start is low the payload lines
  // carry noise, which the block has to ignore. The word is held until the
  // edge at which busy is low.
  task automatic send_word(input item_t it, input int tail_how);
    int              gap;
    logic [CntW-1:0] span;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(8, 24);
    end
    repeat (gap) begin
      @(negedge clk_i);
      start  <= 1'b0;
      item_i <= mk(CmdW'($urandom), LenW'($urandom), {$urandom, $urandom},
                   {$urandom, $urandom});
    end
    @(negedge clk_i);
    // The checker has taken in every earlier word by now, so its head and
    // tail are those the block will see for this one.
    case (tail_how)
      TailAtHead: it.tail_req = ring_head;
      TailInside: begin
        span        = ring_head - ring_tail;
        it.tail_req = ring_tail + ({$urandom, $urandom} % (span + 1));
      end
      TailAtTail: it.tail_req = ring_tail;
      TailAbove:  it.tail_req = ring_head + 1 + $urandom_range(0, 1000);
      TailUnder:  it.tail_req = ring_tail - 1 - $urandom_range(0, 1000);
      default:    ;
    endcase
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  // Lowers start and waits until every predicted word has been seen, then
  // a few cycles more so that the block is surely idle.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Writes both watermarks back to back, valid held high between them.
  task automatic set_marks(input logic [PctW-1:0] high, input logic [PctW-1:0] low);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgHighPercent;
    cfg_data_i  <= high;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i <= CfgLowPercent;
    cfg_data_i  <= low;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly pushes of mixed sizes and advances that stay inside the ring, so
  // that the fill swings through both watermarks and into drop episodes.
  task automatic pick_random(output item_t it, output int how);
    int r;
    int p;
    r   = $urandom_range(0, 99);
    it  = mk(CmdPush, LenW'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    how = TailKeep;
    if (r < 55) begin
      p = $urandom_range(0, 9);
      if (p >= 7) begin
        it.payload_length = LenW'($urandom_range(0, 255));
      end else if (p >= 4) begin
        it.payload_length = LenW'($urandom_range(49152, 65535));
      end
    end else if (r < 85) begin
      it.command = CmdAdvance;
      p = $urandom_range(0, 99);
      if (p < 35) begin
        how = TailAtHead;
      end else if (p < 75) begin
        how = TailInside;
      end else if (p < 83) begin
        how = TailAtTail;
      end else if (p < 89) begin
        how = TailAbove;
      end else if (p < 95) begin
        how = TailUnder;
      end
    end else if (r < 97) begin
      it.command = CmdStatus;
    end else begin
      it.command = CmdReset;
    end
  endtask

  initial begin
    item_t it;
    int    how;
    int    highs[Phases];
    int    lows[Phases];
    highs = '{0, 100, 127, 75, 20, 101, 1, 0};
    lows  = '{0, 100, 127, 25, 60, 0, 127, 0};
    highs[Phases-1] = $urandom_range(0, 127);
    lows[Phases-1]  = $urandom_range(0, 127);
    calm_left    = 0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgHighPercent;
    cfg_data_i   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, run with the watermarks at their reset values.
    send_word(mk(CmdStatus, 16'h0000, '0, '0), TailKeep);
    send_word(mk(CmdPush, 16'h0000, '1, '1), TailKeep);
    send_word(mk(CmdAdvance, 16'hFFFF, '0, '0), TailAbove);
    send_word(mk(CmdAdvance, 16'h0000, '0, '1), TailAtHead);
    // Largest packets until the ring runs out of room: the last of these
    // opens a drop episode, and the next one is lost within it.
    for (int i = 0; i < 16; i++) begin
      send_word(mk(CmdPush, 16'hFFFF, '1, 64'h1000 + i), TailKeep);
    end
    send_word(mk(CmdPush, 16'hFFFF, '0, 64'h2000), TailKeep);
    send_word(mk(CmdAdvance, 16'h0000, '0, '0), TailUnder);
    send_word(mk(CmdAdvance, 16'h0000, '0, '0), TailAtHead);
    // The first push after the episode places the drop record first.
    send_word(mk(CmdPush, 16'd100, '0, 64'h3000), TailKeep);
    send_word(mk(CmdStatus, 16'h0000, '0, '0), TailKeep);
    send_word(mk(CmdReset, 16'h0000, '0, '0), TailKeep);

    // Random part, one phase per watermark setting.
    for (int ph = 0; ph < Phases; ph++) begin
      drain();
      set_marks(PctW'(highs[ph]), PctW'(lows[ph]));
      for (int i = 0; i < PhaseItems; i++) begin
        pick_random(it, how);
        send_word(it, how);
      end
    end

    drain();
    repeat (4) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_ring_producer_watermark_drop OK");
    end else begin
      $display("tb_ring_producer_watermark_drop NOT OK");
    end
    $finish;
  end

endmodule
